// ----- rtl/bssl_pkg.sv -----
// ----------------------------------------------------------------------------
// bssl_pkg
// shared types, constants and commutation tables of the bldc speed loop
// ----------------------------------------------------------------------------
`default_nettype none

package bssl_pkg;

   // default pwm scale for one full accumulator (+1.0)
   localparam int unsigned DUTY_SCALE_DEFAULT = 1024;

   // accumulator format
   localparam int ACC_W      = 32;
   localparam int ACC_FRAC_W = 30;

   // field widths
   localparam int VEL_W    = 16;
   localparam int ERR_W    = 17;
   localparam int GAIN_W   = 32;
   localparam int HALL_W   = 3;
   localparam int MODE_W   = 2;
   localparam int MODES_W  = 6;
   localparam int DUTY_W   = 11;
   localparam int SECTOR_W = 3;

   // largest duty the result field carries
   localparam logic [DUTY_W-1:0] DUTY_MAX = '1;

   // csr register indexes
   localparam int CSR_INDEX_W = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_KP_GAIN   = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KI_GAIN   = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KD_GAIN   = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_REF_COUNT = 8'd3;

   // csr reset values
   localparam logic signed [GAIN_W-1:0] KP_GAIN_RESET   = 32'sd32212;
   localparam logic signed [GAIN_W-1:0] KI_GAIN_RESET   = 32'sd3221;
   localparam logic signed [GAIN_W-1:0] KD_GAIN_RESET   = 32'sd0;
   localparam logic signed [VEL_W-1:0]  REF_COUNT_RESET = 16'sd0;

   // phase gate modes
   localparam logic [MODE_W-1:0] MODE_PWM = 2'd0;
   localparam logic [MODE_W-1:0] MODE_OFF = 2'd1;
   localparam logic [MODE_W-1:0] MODE_LOW = 2'd2;

   // sector meaning no valid hall code
   localparam logic [SECTOR_W-1:0] SECTOR_NONE = 3'd0;

   localparam logic [MODES_W-1:0] MODES_ALL_OFF = {MODE_OFF, MODE_OFF, MODE_OFF};
   localparam logic [MODES_W-1:0] MODES_ALL_LOW = {MODE_LOW, MODE_LOW, MODE_LOW};

   // result of the pid stage, handed to the commutation stage
   typedef struct packed {
      logic signed [ACC_W-1:0] acc;
      logic                    full_speed;
      logic [SECTOR_W-1:0]     hall_sector;
   } pid_result_type;

   // hall1 hall2 hall3 to sector
   function automatic logic [SECTOR_W-1:0] hall_to_sector(input logic [HALL_W-1:0] code);
      logic [SECTOR_W-1:0] s;
      case (code)
         3'b001:  s = 3'd1;
         3'b010:  s = 3'd3;
         3'b011:  s = 3'd2;
         3'b100:  s = 3'd5;
         3'b101:  s = 3'd6;
         3'b110:  s = 3'd4;
         default: s = SECTOR_NONE;
      endcase
      return s;
   endfunction

   // packed modes: phase c in the top bits, phase a in the bottom bits
   function automatic logic [MODES_W-1:0] ccw_modes(input logic [SECTOR_W-1:0] sector);
      logic [MODES_W-1:0] m;
      case (sector)
         3'd1:    m = {MODE_LOW, MODE_OFF, MODE_PWM};
         3'd2:    m = {MODE_LOW, MODE_PWM, MODE_OFF};
         3'd3:    m = {MODE_OFF, MODE_PWM, MODE_LOW};
         3'd4:    m = {MODE_PWM, MODE_OFF, MODE_LOW};
         3'd5:    m = {MODE_PWM, MODE_LOW, MODE_OFF};
         3'd6:    m = {MODE_OFF, MODE_LOW, MODE_PWM};
         default: m = '0;
      endcase
      return m;
   endfunction

   function automatic logic [MODES_W-1:0] cw_modes(input logic [SECTOR_W-1:0] sector);
      logic [MODES_W-1:0] m;
      case (sector)
         3'd1:    m = {MODE_LOW, MODE_PWM, MODE_OFF};
         3'd2:    m = {MODE_OFF, MODE_PWM, MODE_LOW};
         3'd3:    m = {MODE_PWM, MODE_OFF, MODE_LOW};
         3'd4:    m = {MODE_PWM, MODE_LOW, MODE_OFF};
         3'd5:    m = {MODE_OFF, MODE_LOW, MODE_PWM};
         3'd6:    m = {MODE_LOW, MODE_OFF, MODE_PWM};
         default: m = '0;
      endcase
      return m;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/bldc_speed_loop_six_step.sv -----
// ----------------------------------------------------------------------------
// bldc_speed_loop_six_step
// brushless motor speed loop with hall-sensor six-step commutation
// ----------------------------------------------------------------------------
// One beat on req_ is one sample tick: measured encoder counts and the three
// hall bits. The block forms the speed error against ref_count, adds an
// incremental pid step to a q1.30 drive accumulator clamped to +-1.0, scales
// it to a signed pwm duty and picks the gate mode of each phase from the hall
// sector and the duty sign. One rsp_ beat comes out for every req_ beat, in
// order. Throughput is one beat per clock while rsp_tready is high. A beat
// passes three registers in order (input register, pid stage with its three
// gain multipliers, commutation stage with the duty scaling) and leaves the
// last one, the result register, when rsp_tready is high. The three stages
// only close up behind a stalled result, so req_tready stays high while a
// result waits as long as a stage is free. Gains and ref_count are written
// over the csr_ channel, which is always ready, and should only change while
// no beat is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module bldc_speed_loop_six_step #(
   parameter int unsigned DUTY_SCALE = bssl_pkg::DUTY_SCALE_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // sample input
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [23:0]                          req_tdata,  // velocity_count, hall_bits
   // result output
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // phase_a_mode, phase_b_mode, phase_c_mode, duty_magnitude, spin_direction,
   // full_speed, hall_sector
   output logic [23:0]                               rsp_tdata,
   // register writes
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [bssl_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [31:0]                          csr_data
);

   // configuration registers
   logic signed [bssl_pkg::GAIN_W-1:0] kp_ff, kp_in;
   logic signed [bssl_pkg::GAIN_W-1:0] ki_ff, ki_in;
   logic signed [bssl_pkg::GAIN_W-1:0] kd_ff, kd_in;
   logic signed [bssl_pkg::VEL_W-1:0]  ref_ff, ref_in;

   // stage occupancy
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic s3_valid_ff, s3_valid_in;
   logic s1_load, s2_load, s3_load;

   // input register
   logic signed [bssl_pkg::VEL_W-1:0] vel_ff, vel_in;
   logic [bssl_pkg::HALL_W-1:0]       hall_ff, hall_in;

   bssl_pkg::pid_result_type          pid_result;
   logic [bssl_pkg::MODES_W-1:0]      phase_modes;
   logic [bssl_pkg::DUTY_W-1:0]       duty_magnitude;
   logic                              spin_direction;
   logic                              full_speed;
   logic [bssl_pkg::SECTOR_W-1:0]     hall_sector;

   // csr writes, always taken
   assign csr_ready = 1'b1;

   always_comb begin
      kp_in  = kp_ff;
      ki_in  = ki_ff;
      kd_in  = kd_ff;
      ref_in = ref_ff;
      if (csr_valid) begin
         case (csr_index)
            bssl_pkg::CSR_KP_GAIN:   kp_in  = csr_data;
            bssl_pkg::CSR_KI_GAIN:   ki_in  = csr_data;
            bssl_pkg::CSR_KD_GAIN:   kd_in  = csr_data;
            bssl_pkg::CSR_REF_COUNT: ref_in = csr_data[bssl_pkg::VEL_W-1:0];
            default: ; // unknown index ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff  <= bssl_pkg::KP_GAIN_RESET;
         ki_ff  <= bssl_pkg::KI_GAIN_RESET;
         kd_ff  <= bssl_pkg::KD_GAIN_RESET;
         ref_ff <= bssl_pkg::REF_COUNT_RESET;
      end else begin
         kp_ff  <= kp_in;
         ki_ff  <= ki_in;
         kd_ff  <= kd_in;
         ref_ff <= ref_in;
      end
   end

   // a stage loads when it is empty or its contents move on
   always_comb begin
      s3_load     = !s3_valid_ff || rsp_tready;
      s2_load     = !s2_valid_ff || s3_load;
      s1_load     = !s1_valid_ff || s2_load;
      s1_valid_in = s1_load ? req_tvalid  : s1_valid_ff;
      s2_valid_in = s2_load ? s1_valid_ff : s2_valid_ff;
      s3_valid_in = s3_load ? s2_valid_ff : s3_valid_ff;

      vel_in  = vel_ff;
      hall_in = hall_ff;
      if (s1_load && req_tvalid) begin
         vel_in  = req_tdata[bssl_pkg::VEL_W-1:0];
         hall_in = req_tdata[bssl_pkg::VEL_W +: bssl_pkg::HALL_W];
      end
   end

   assign req_tready = s1_load;
   assign rsp_tvalid = s3_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      vel_ff  <= vel_in;
      hall_ff <= hall_in;
   end

   // pid step; error history and accumulator advance once per beat
   bssl_pid_stage u_pid (
      .clock          (clock),
      .reset          (reset),
      .step           (s2_load && s1_valid_ff),
      .velocity_count (vel_ff),
      .hall_bits      (hall_ff),
      .kp_gain        (kp_ff),
      .ki_gain        (ki_ff),
      .kd_gain        (kd_ff),
      .ref_count      (ref_ff),
      .result         (pid_result)
   );

   // duty and gate modes; held modes survive an invalid hall code while the duty is nonzero
   bssl_commutator #(
      .DUTY_SCALE (DUTY_SCALE)
   ) u_commutator (
      .clock          (clock),
      .reset          (reset),
      .step           (s3_load && s2_valid_ff),
      .pid            (pid_result),
      .phase_modes    (phase_modes),
      .duty_magnitude (duty_magnitude),
      .spin_direction (spin_direction),
      .full_speed     (full_speed),
      .hall_sector    (hall_sector)
   );

   assign rsp_tdata = {2'b00, hall_sector, full_speed, spin_direction, duty_magnitude,
                       phase_modes};

endmodule

`default_nettype wire

// ----- rtl/bssl_pid_stage.sv -----
// ----------------------------------------------------------------------------
// bssl_pid_stage
// incremental pid step on the velocity error, clamped q1.30 accumulator
// ----------------------------------------------------------------------------
`default_nettype none

module bssl_pid_stage (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  step,
   input  wire logic signed [bssl_pkg::VEL_W-1:0]     velocity_count,
   input  wire logic [bssl_pkg::HALL_W-1:0]           hall_bits,
   input  wire logic signed [bssl_pkg::GAIN_W-1:0]    kp_gain,
   input  wire logic signed [bssl_pkg::GAIN_W-1:0]    ki_gain,
   input  wire logic signed [bssl_pkg::GAIN_W-1:0]    kd_gain,
   input  wire logic signed [bssl_pkg::VEL_W-1:0]     ref_count,
   output bssl_pkg::pid_result_type                   result
);

   localparam int PROD_W = bssl_pkg::GAIN_W + bssl_pkg::ERR_W;
   localparam int SUM_W  = PROD_W + 3;
   localparam logic signed [SUM_W-1:0] ACC_ONE     = SUM_W'(64'sd1 <<< bssl_pkg::ACC_FRAC_W);
   localparam logic signed [SUM_W-1:0] ACC_NEG_ONE = -ACC_ONE;

   logic signed [bssl_pkg::ERR_W-1:0] err_last_ff, err_last_in;
   logic signed [bssl_pkg::ERR_W-1:0] err_prev_ff, err_prev_in;
   logic signed [bssl_pkg::ACC_W-1:0] acc_ff, acc_in;
   bssl_pkg::pid_result_type          result_ff, result_in;

   logic signed [bssl_pkg::ERR_W-1:0] err_now;
   logic signed [PROD_W-1:0]          prod_i, prod_p, prod_d;
   logic signed [SUM_W-1:0]           sum;
   logic signed [SUM_W-1:0]           sum_clamped;
   logic                              clamped;

   always_comb begin
      err_now = bssl_pkg::ERR_W'(ref_count) - bssl_pkg::ERR_W'(velocity_count);
      prod_i  = PROD_W'(ki_gain) * PROD_W'(err_now);
      prod_p  = PROD_W'(kp_gain) * PROD_W'(err_last_ff);
      prod_d  = PROD_W'(kd_gain) * PROD_W'(err_prev_ff);
      sum     = SUM_W'(acc_ff) + SUM_W'(prod_i) + SUM_W'(prod_p) + SUM_W'(prod_d);

      clamped     = 1'b0;
      sum_clamped = sum;
      if (sum >= ACC_ONE) begin
         sum_clamped = ACC_ONE;
         clamped     = 1'b1;
      end else if (sum < ACC_NEG_ONE) begin
         sum_clamped = ACC_NEG_ONE;
         clamped     = 1'b1;
      end

      err_last_in = err_last_ff;
      err_prev_in = err_prev_ff;
      acc_in      = acc_ff;
      result_in   = result_ff;
      if (step) begin
         err_last_in           = err_now;
         err_prev_in           = err_last_ff;
         acc_in                = bssl_pkg::ACC_W'(sum_clamped);
         result_in.acc         = bssl_pkg::ACC_W'(sum_clamped);
         result_in.full_speed  = clamped;
         result_in.hall_sector = bssl_pkg::hall_to_sector(hall_bits);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         err_last_ff <= '0;
         err_prev_ff <= '0;
         acc_ff      <= '0;
      end else begin
         err_last_ff <= err_last_in;
         err_prev_ff <= err_prev_in;
         acc_ff      <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

`default_nettype wire

// ----- rtl/bssl_commutator.sv -----
// ----------------------------------------------------------------------------
// bssl_commutator
// duty scaling and six-step phase selection, result register
// ----------------------------------------------------------------------------
`default_nettype none

module bssl_commutator #(
   parameter int unsigned DUTY_SCALE = bssl_pkg::DUTY_SCALE_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                step,
   input  wire bssl_pkg::pid_result_type            pid,
   output logic [bssl_pkg::MODES_W-1:0]             phase_modes,
   output logic [bssl_pkg::DUTY_W-1:0]              duty_magnitude,
   output logic                                     spin_direction,
   output logic                                     full_speed,
   output logic [bssl_pkg::SECTOR_W-1:0]            hall_sector
);

   localparam int SCALE_W = $clog2(DUTY_SCALE + 1);
   localparam int MAG_W   = bssl_pkg::ACC_W - 1;
   localparam int PROD_W  = MAG_W + SCALE_W;
   localparam logic [SCALE_W-1:0] SCALE = SCALE_W'(DUTY_SCALE);

   logic [bssl_pkg::MODES_W-1:0]  held_ff, held_in;
   logic [bssl_pkg::DUTY_W-1:0]   duty_ff, duty_in;
   logic                          dir_ff, dir_in;
   logic                          full_ff, full_in;
   logic [bssl_pkg::SECTOR_W-1:0] sector_ff, sector_in;

   logic [MAG_W-1:0]  acc_abs;
   logic [PROD_W-1:0] scaled;
   logic [31:0]       duty_wide;
   logic              duty_zero;
   logic              cw;

   always_comb begin
      // |acc| never exceeds 2^30, so it fits one bit less than acc
      acc_abs   = pid.acc[bssl_pkg::ACC_W-1] ? MAG_W'(-pid.acc) : MAG_W'(pid.acc);
      scaled    = PROD_W'(acc_abs) * PROD_W'(SCALE);
      // truncation toward zero: scale the magnitude then drop the fraction
      duty_wide = 32'(scaled >> bssl_pkg::ACC_FRAC_W);
      duty_zero = (duty_wide == 32'd0);
      cw        = !duty_zero && !pid.acc[bssl_pkg::ACC_W-1];

      held_in   = held_ff;
      duty_in   = duty_ff;
      dir_in    = dir_ff;
      full_in   = full_ff;
      sector_in = sector_ff;
      if (step) begin
         if (pid.hall_sector != bssl_pkg::SECTOR_NONE) begin
            held_in = cw ? bssl_pkg::cw_modes(pid.hall_sector)
                         : bssl_pkg::ccw_modes(pid.hall_sector);
         end
         if (duty_zero) begin
            held_in = bssl_pkg::MODES_ALL_LOW;
         end
         duty_in   = (duty_wide > 32'(bssl_pkg::DUTY_MAX)) ? bssl_pkg::DUTY_MAX
                                                          : bssl_pkg::DUTY_W'(duty_wide);
         dir_in    = cw;
         full_in   = pid.full_speed;
         sector_in = pid.hall_sector;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= bssl_pkg::MODES_ALL_OFF;
      end else begin
         held_ff <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      duty_ff   <= duty_in;
      dir_ff    <= dir_in;
      full_ff   <= full_in;
      sector_ff <= sector_in;
   end

   assign phase_modes    = held_ff;
   assign duty_magnitude = duty_ff;
   assign spin_direction = dir_ff;
   assign full_speed     = full_ff;
   assign hall_sector    = sector_ff;

endmodule

`default_nettype wire
